// ===== design/sfc_pkg.sv =====
`default_nettype none
package sfc_pkg;

   localparam int NUM_SLOTS_DEF = 6;
   localparam int MAX_PAYLOAD   = 4;

   // status codes
   localparam logic [2:0] ST_STORED  = 3'd0;
   localparam logic [2:0] ST_BAD_LEN = 3'd1;
   localparam logic [2:0] ST_BAD_SUM = 3'd2;
   localparam logic [2:0] ST_BAD_ID  = 3'd3;
   localparam logic [2:0] ST_SHORT   = 3'd4;

   // source ports
   localparam logic [1:0] SRC_LEFT  = 2'd0;
   localparam logic [1:0] SRC_RIGHT = 2'd1;
   localparam logic [1:0] SRC_PROBE = 2'd2;

   // csr indexes
   localparam logic [2:0] CSR_LEFT_SLOT    = 3'd0;
   localparam logic [2:0] CSR_RIGHT_SLOT   = 3'd1;
   localparam logic [2:0] CSR_PROBE_FIRST  = 3'd2;
   localparam logic [2:0] CSR_PROBE_SECOND = 3'd3;
   localparam logic [2:0] CSR_PROBE_THIRD  = 3'd4;
   localparam logic [2:0] CSR_PROBE_FOURTH = 3'd5;

   localparam int NUM_PROBES = 4;
   localparam int TEMP_W     = 13;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [15:0] object_raw;
      logic [15:0] ambient_raw;
   } verdict_type;

   // x / 10 for 16-bit x: reciprocal 0xCCCD scaled by 2^19, exact over the full range
   function automatic logic [TEMP_W-1:0] div10(input logic [15:0] x);
      logic [32:0] prod;
      prod = {17'd0, x} * 33'd52429;
      return prod[31:19];
   endfunction

endpackage
`default_nettype wire

// ===== design/sfc_req_if.sv =====
`default_nettype none
interface sfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [1:0] src_port;
   logic       last_byte;

   modport source (output valid, output frame_byte, output src_port, output last_byte,
                   input ready);
   modport sink (input valid, input frame_byte, input src_port, input last_byte,
                 output ready);
endinterface
`default_nettype wire

// ===== design/sfc_rsp_if.sv =====
`default_nettype none
interface sfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  slot;
   logic [12:0] object_temp;
   logic [12:0] ambient_temp;
   logic [12:0] body_temp;

   modport source (output valid, output status, output slot, output object_temp,
                   output ambient_temp, output body_temp, input ready);
   modport sink (input valid, input status, input slot, input object_temp,
                 input ambient_temp, input body_temp, output ready);
endinterface
`default_nettype wire

// ===== design/sensor_frame_checksum_parser.sv =====
// After its last byte is taken, a frame's result moves through the input register,
// parse/verdict register, divide register and output register.
// Throughput: one byte per cycle sustained; stalls only under rsp back-pressure.
// Reset: parser state and slot table cleared, slot/ID registers back to 1..6,
// pipeline emptied. No clearing pass; ready is low during reset, high as it drops.
`default_nettype none
module sensor_frame_checksum_parser #(
   parameter int NUM_SLOTS = sfc_pkg::NUM_SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [2:0] csr_wdata,
   sfc_req_if.sink         req_bus,
   sfc_rsp_if.source       rsp_bus
);

   // configuration
   logic [2:0] left_slot_ff;
   logic [2:0] right_slot_ff;
   logic [2:0] probe_id_ff [sfc_pkg::NUM_PROBES];

   always_ff @(posedge clock) begin
      if (reset) begin
         left_slot_ff   <= 3'd1;
         right_slot_ff  <= 3'd2;
         probe_id_ff[0] <= 3'd3;
         probe_id_ff[1] <= 3'd4;
         probe_id_ff[2] <= 3'd5;
         probe_id_ff[3] <= 3'd6;
      end else if (csr_we) begin
         case (csr_index)
            sfc_pkg::CSR_LEFT_SLOT:    left_slot_ff   <= csr_wdata;
            sfc_pkg::CSR_RIGHT_SLOT:   right_slot_ff  <= csr_wdata;
            sfc_pkg::CSR_PROBE_FIRST:  probe_id_ff[0] <= csr_wdata;
            sfc_pkg::CSR_PROBE_SECOND: probe_id_ff[1] <= csr_wdata;
            sfc_pkg::CSR_PROBE_THIRD:  probe_id_ff[2] <= csr_wdata;
            sfc_pkg::CSR_PROBE_FOURTH: probe_id_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [1:0] in_src_ff;
   logic       in_last_ff;

   logic in_proc;
   logic in_free;
   logic verdict_free;
   logic verdict_ready;

   logic                 verdict_valid_ff;
   sfc_pkg::verdict_type verdict_ff;
   sfc_pkg::verdict_type verdict_in;

   assign verdict_free  = !verdict_valid_ff || verdict_ready;
   assign in_proc       = in_valid_ff && (!in_last_ff || verdict_free);
   assign in_free       = !in_valid_ff || in_proc;
   assign req_bus.ready = in_free && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && in_free) begin
         in_valid_ff <= 1'b1;
      end else if (in_proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && in_free) begin
         in_byte_ff <= req_bus.frame_byte;
         in_src_ff  <= req_bus.src_port;
         in_last_ff <= req_bus.last_byte;
      end
   end

   // parser state
   logic [3:0]  pos_ff, pos_in, pos_upd;
   logic [7:0]  sum_ff, sum_in, sum_upd;
   logic [7:0]  len_ff, len_upd;
   logic [15:0] obj_raw_ff, obj_upd;
   logic [15:0] amb_raw_ff, amb_upd;
   logic [7:0]  chk_ff, chk_upd;
   logic [7:0]  id_ff, id_upd;
   logic [8:0]  len_plus4;

   assign len_plus4 = {1'b0, len_ff} + 9'd4;

   always_comb begin
      sum_upd = sum_ff;
      len_upd = len_ff;
      obj_upd = obj_raw_ff;
      amb_upd = amb_raw_ff;
      chk_upd = chk_ff;
      id_upd  = id_ff;
      if (pos_ff < 4'd4 || {5'd0, pos_ff} < len_plus4) sum_upd = sum_ff + in_byte_ff;
      case (pos_ff)
         4'd3: len_upd = in_byte_ff;
         4'd4: obj_upd[15:8] = in_byte_ff;
         4'd5: obj_upd[7:0]  = in_byte_ff;
         4'd6: amb_upd[15:8] = in_byte_ff;
         4'd7: amb_upd[7:0]  = in_byte_ff;
         default: ;
      endcase
      if (pos_ff >= 4'd4 && {5'd0, pos_ff} == len_plus4) chk_upd = in_byte_ff;
      if (pos_ff >= 4'd5 && {5'd0, pos_ff} == len_plus4 + 9'd1) id_upd = in_byte_ff;
      pos_upd = (pos_ff == 4'hF) ? pos_ff : pos_ff + 4'd1;
      // a marked last byte restarts the frame
      pos_in = in_last_ff ? 4'd0 : pos_upd;
      sum_in = in_last_ff ? 8'd0 : sum_upd;
   end

   // frame verdict from the state as it stands after this byte
   always_comb begin
      logic [8:0] need;
      logic [2:0] slot_sel;
      logic       slot_ok;
      need     = {1'b0, len_upd} + ((in_src_ff == sfc_pkg::SRC_PROBE) ? 9'd6 : 9'd5);
      slot_sel = 3'd0;
      slot_ok  = 1'b0;
      if (need < 9'd8) need = 9'd8;
      verdict_in.status      = sfc_pkg::ST_STORED;
      verdict_in.object_raw  = obj_upd;
      verdict_in.ambient_raw = amb_upd;
      if (pos_upd < 4'd4) begin
         verdict_in.status = sfc_pkg::ST_SHORT;
      end else if (len_upd > 8'(sfc_pkg::MAX_PAYLOAD)) begin
         verdict_in.status = sfc_pkg::ST_BAD_LEN;
      end else if ({5'd0, pos_upd} < need) begin
         verdict_in.status = sfc_pkg::ST_SHORT;
      end else if (sum_upd != chk_upd) begin
         verdict_in.status = sfc_pkg::ST_BAD_SUM;
      end else begin
         case (in_src_ff)
            sfc_pkg::SRC_LEFT: begin
               slot_sel = left_slot_ff;
               slot_ok  = 1'b1;
            end
            sfc_pkg::SRC_RIGHT: begin
               slot_sel = right_slot_ff;
               slot_ok  = 1'b1;
            end
            sfc_pkg::SRC_PROBE: begin
               // scan backward so the first matching ID wins
               for (int k = sfc_pkg::NUM_PROBES - 1; k >= 0; k--) begin
                  if (id_upd == {5'd0, probe_id_ff[k]}) begin
                     slot_sel = probe_id_ff[k];
                     slot_ok  = 1'b1;
                  end
               end
            end
            default: slot_ok = 1'b0;
         endcase
         if (!slot_ok || slot_sel == 3'd0 || int'(slot_sel) > NUM_SLOTS) begin
            verdict_in.status = sfc_pkg::ST_BAD_ID;
         end
      end
      verdict_in.slot = (verdict_in.status == sfc_pkg::ST_STORED) ? slot_sel : 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         sum_ff     <= '0;
         len_ff     <= '0;
         obj_raw_ff <= '0;
         amb_raw_ff <= '0;
         chk_ff     <= '0;
         id_ff      <= '0;
      end else if (in_proc) begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         len_ff     <= len_upd;
         obj_raw_ff <= obj_upd;
         amb_raw_ff <= amb_upd;
         chk_ff     <= chk_upd;
         id_ff      <= id_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_valid_ff <= 1'b0;
      end else if (in_proc && in_last_ff) begin
         verdict_valid_ff <= 1'b1;
      end else if (verdict_ready) begin
         verdict_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_proc && in_last_ff) verdict_ff <= verdict_in;
   end

   sfc_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .verdict_valid (verdict_valid_ff),
      .verdict       (verdict_ff),
      .verdict_ready (verdict_ready),
      .rsp_bus       (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== design/sfc_store.sv =====
`default_nettype none
module sfc_store #(
   parameter int NUM_SLOTS = sfc_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                verdict_valid,
   input  wire sfc_pkg::verdict_type verdict,
   output logic                     verdict_ready,
   sfc_rsp_if.source                rsp_bus
);

   localparam int TW = sfc_pkg::TEMP_W;

   // quotient stage
   logic          q_valid_ff;
   logic [2:0]    q_status_ff;
   logic [2:0]    q_slot_ff;
   logic [TW-1:0] q_obj_ff;
   logic [TW-1:0] q_amb_ff;

   // output register
   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [2:0]    rsp_slot_ff;
   logic [TW-1:0] rsp_obj_ff;
   logic [TW-1:0] rsp_amb_ff;
   logic [TW-1:0] rsp_body_ff;

   logic [TW-1:0] obj_tab_ff [NUM_SLOTS];

   logic          out_free;
   logic          q_take;
   logic          stored;
   logic [TW-1:0] body_in;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign verdict_ready = !q_valid_ff || out_free;
   assign q_take        = q_valid_ff && out_free;
   assign stored        = (q_status_ff == sfc_pkg::ST_STORED);

   // max over the table with this transaction's write folded in
   always_comb begin
      logic [TW-1:0] cand;
      body_in = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         cand = obj_tab_ff[k];
         if (stored && int'(q_slot_ff) == k + 1) cand = q_obj_ff;
         if (cand > body_in) body_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else if (verdict_valid && verdict_ready) begin
         q_valid_ff <= 1'b1;
      end else if (q_take) begin
         q_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict_valid && verdict_ready) begin
         q_status_ff <= verdict.status;
         q_slot_ff   <= verdict.slot;
         q_obj_ff    <= sfc_pkg::div10(verdict.object_raw);
         q_amb_ff    <= sfc_pkg::div10(verdict.ambient_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SLOTS; k++) obj_tab_ff[k] <= '0;
      end else if (q_take && stored) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            if (int'(q_slot_ff) == k + 1) obj_tab_ff[k] <= q_obj_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_take) begin
         rsp_status_ff <= q_status_ff;
         rsp_slot_ff   <= stored ? q_slot_ff : 3'd0;
         rsp_obj_ff    <= stored ? q_obj_ff : '0;
         rsp_amb_ff    <= stored ? q_amb_ff : '0;
         rsp_body_ff   <= body_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.slot         = rsp_slot_ff;
   assign rsp_bus.object_temp  = rsp_obj_ff;
   assign rsp_bus.ambient_temp = rsp_amb_ff;
   assign rsp_bus.body_temp    = rsp_body_ff;

endmodule
`default_nettype wire

// ===== sim/tb_sensor_frame_checksum_parser.sv =====
`timescale 1ns / 1ps
module tb_sensor_frame_checksum_parser;

   localparam int SLOT_COUNT    = sfc_pkg::NUM_SLOTS_DEF;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int MAX_SHOWN     = 10;

   // source code with no port behind it
   localparam logic [1:0] SRC_NONE = 2'd3;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [12:0] object_temp;
      logic [12:0] ambient_temp;
      logic [12:0] body_temp;
   } report_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [2:0] csr_wdata;

   sfc_req_if req_bus();
   sfc_rsp_if rsp_bus();

   sensor_frame_checksum_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   always #5 clock = ~clock;

   // parser model: configuration, frame state and slot table
   logic [2:0]  left_slot_cfg;
   logic [2:0]  right_slot_cfg;
   logic [2:0]  probe_id_cfg [sfc_pkg::NUM_PROBES];
   int          byte_pos;
   logic [7:0]  sum_acc;
   logic [7:0]  frame_len;
   logic [7:0]  check_byte;
   logic [7:0]  id_byte;
   logic [15:0] object_word;
   logic [15:0] ambient_word;
   logic [12:0] slot_object_tbl [1:SLOT_COUNT];
   logic [12:0] slot_ambient_tbl [1:SLOT_COUNT];
   report_type  expected_reports [$];

   bit offering;
   bit no_gaps;
   bit hold_request;
   int errors;
   int shown;
   int bytes_sent;
   int frames_sent;
   int reports_checked;
   int stored_seen;
   int cycle_count;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                  expected_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void absorb_byte(input logic [7:0] b, input logic [1:0] src,
                                       input logic last);
      int         p;
      int         len;
      int         need;
      logic [2:0] slot_sel;
      logic       found;
      report_type rep;
      p = byte_pos;
      len = frame_len;
      if (p < 4 || p < len + 4) sum_acc = sum_acc + b;
      if (p == 3) frame_len = b;
      case (p)
         4: object_word[15:8] = b;
         5: object_word[7:0] = b;
         6: ambient_word[15:8] = b;
         7: ambient_word[7:0] = b;
         default: ;
      endcase
      if (p >= 4 && p == len + 4) check_byte = b;
      if (p >= 5 && p == len + 5) id_byte = b;
      if (byte_pos < 15) byte_pos++;
      if (!last) return;

      rep = '0;
      slot_sel = '0;
      found = 1'b0;
      need = frame_len + ((src == sfc_pkg::SRC_PROBE) ? 6 : 5);
      if (need < 8) need = 8;
      if (byte_pos < 4) rep.status = sfc_pkg::ST_SHORT;
      else if (frame_len > sfc_pkg::MAX_PAYLOAD) rep.status = sfc_pkg::ST_BAD_LEN;
      else if (byte_pos < need) rep.status = sfc_pkg::ST_SHORT;
      else if (sum_acc != check_byte) rep.status = sfc_pkg::ST_BAD_SUM;
      else begin
         case (src)
            sfc_pkg::SRC_LEFT: begin
               slot_sel = left_slot_cfg;
               found = 1'b1;
            end
            sfc_pkg::SRC_RIGHT: begin
               slot_sel = right_slot_cfg;
               found = 1'b1;
            end
            sfc_pkg::SRC_PROBE: begin
               // first matching ID wins
               for (int k = 0; k < sfc_pkg::NUM_PROBES; k++) begin
                  if (!found && {5'd0, probe_id_cfg[k]} == id_byte) begin
                     slot_sel = probe_id_cfg[k];
                     found = 1'b1;
                  end
               end
            end
            default: found = 1'b0;
         endcase
         if (!found || slot_sel < 1 || slot_sel > SLOT_COUNT) rep.status = sfc_pkg::ST_BAD_ID;
         else begin
            slot_object_tbl[slot_sel] = 13'(object_word / 10);
            slot_ambient_tbl[slot_sel] = 13'(ambient_word / 10);
            rep.status = sfc_pkg::ST_STORED;
            rep.slot = slot_sel;
            rep.object_temp = slot_object_tbl[slot_sel];
            rep.ambient_temp = slot_ambient_tbl[slot_sel];
         end
      end
      for (int k = 1; k <= SLOT_COUNT; k++)
         if (slot_object_tbl[k] > rep.body_temp) rep.body_temp = slot_object_tbl[k];
      expected_reports.push_back(rep);
      byte_pos = 0;
      sum_acc = '0;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic int pick_gap();
      if (no_gaps || $urandom_range(0, 99) < 55) return 0;
      return gap_length();
   endfunction

   function automatic logic [15:0] pick_reading();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // well-formed frame; with len below 4 the check byte, and with len below 3 the ID byte, overlap the readings
   function automatic void build_frame(output logic [7:0] fbytes[$], input int len,
                                       input logic [1:0] src, input logic [15:0] obj,
                                       input logic [15:0] amb, input logic [7:0] id);
      int         need;
      logic [7:0] s;
      need = len + ((src == sfc_pkg::SRC_PROBE) ? 6 : 5);
      if (need < 8) need = 8;
      fbytes = {};
      for (int i = 0; i < need; i++) fbytes.push_back(8'($urandom));
      fbytes[3] = 8'(len);
      fbytes[4] = obj[15:8];
      fbytes[5] = obj[7:0];
      fbytes[6] = amb[15:8];
      fbytes[7] = amb[7:0];
      s = '0;
      for (int i = 0; i < len + 4; i++) s = s + fbytes[i];
      fbytes[len + 4] = s;
      if (src == sfc_pkg::SRC_PROBE) fbytes[len + 5] = id;
   endfunction

   // one request transaction; valid stays up on return so back-to-back bytes need no drop
   task automatic send_byte(input logic [7:0] b, input logic [1:0] src, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0 && offering) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      else if (gap > 0) repeat (gap) @(posedge clock);
      req_bus.valid <= 1'b1;
      req_bus.frame_byte <= b;
      req_bus.src_port <= src;
      req_bus.last_byte <= last;
      offering = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      absorb_byte(b, src, last);
      bytes_sent++;
   endtask

   task automatic idle_input();
      if (offering) req_bus.valid <= 1'b0;
      offering = 1'b0;
   endtask

   task automatic send_frame(input logic [7:0] fbytes[$], input logic [1:0] src,
                             input logic mix_src);
      logic [1:0] byte_src;
      for (int i = 0; i < fbytes.size(); i++) begin
         byte_src = src;
         // only the marked byte's source counts
         if (mix_src && i != fbytes.size() - 1) byte_src = 2'($urandom_range(0, 3));
         send_byte(fbytes[i], byte_src, i == fbytes.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic wait_drain();
      idle_input();
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [2:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sfc_pkg::CSR_LEFT_SLOT:    left_slot_cfg = val;
         sfc_pkg::CSR_RIGHT_SLOT:   right_slot_cfg = val;
         sfc_pkg::CSR_PROBE_FIRST:  probe_id_cfg[0] = val;
         sfc_pkg::CSR_PROBE_SECOND: probe_id_cfg[1] = val;
         sfc_pkg::CSR_PROBE_THIRD:  probe_id_cfg[2] = val;
         sfc_pkg::CSR_PROBE_FOURTH: probe_id_cfg[3] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [2:0] left, input logic [2:0] right,
                               input logic [2:0] p0, input logic [2:0] p1,
                               input logic [2:0] p2, input logic [2:0] p3);
      write_csr(sfc_pkg::CSR_LEFT_SLOT, left);
      write_csr(sfc_pkg::CSR_RIGHT_SLOT, right);
      write_csr(sfc_pkg::CSR_PROBE_FIRST, p0);
      write_csr(sfc_pkg::CSR_PROBE_SECOND, p1);
      write_csr(sfc_pkg::CSR_PROBE_THIRD, p2);
      write_csr(sfc_pkg::CSR_PROBE_FOURTH, p3);
   endtask

   task automatic send_random_frame();
      logic [7:0]  fb[$];
      logic [1:0]  src;
      logic [15:0] obj;
      logic [15:0] amb;
      logic [7:0]  id;
      int          len;
      int          mode;
      int          cut;
      if ($urandom_range(0, 19) == 0) src = SRC_NONE;
      else src = 2'($urandom_range(0, 2));
      len = $urandom_range(0, sfc_pkg::MAX_PAYLOAD);
      obj = pick_reading();
      amb = pick_reading();
      if ($urandom_range(0, 6) == 0) id = 8'($urandom);
      else id = {5'd0, probe_id_cfg[$urandom_range(0, sfc_pkg::NUM_PROBES - 1)]};
      build_frame(fb, len, src, obj, amb, id);
      mode = $urandom_range(0, 99);
      if (mode < 8) fb[len + 4] = fb[len + 4] + 8'($urandom_range(1, 255));
      else if (mode < 14) fb[3] = 8'($urandom_range(sfc_pkg::MAX_PAYLOAD + 1, 255));
      else if (mode < 22) begin
         cut = $urandom_range(1, fb.size() - 1);
         while (fb.size() > cut) void'(fb.pop_back());
      end
      else if (mode < 32) repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom));
      else if (mode < 36) repeat ($urandom_range(1, 3)) fb.push_front(8'($urandom));
      send_frame(fb, src, 1'b1);
   endtask

   task automatic run_random_traffic(input int byte_budget);
      int target;
      target = bytes_sent + byte_budget;
      while (bytes_sent < target) send_random_frame();
      wait_drain();
   endtask

   task automatic test_directed_frames();
      logic [7:0] fb[$];
      // header cut after one byte
      fb = {8'hA5};
      send_frame(fb, sfc_pkg::SRC_LEFT, 1'b0);
      // largest length byte
      fb = {8'h00, 8'hFF, 8'h00, 8'hFF};
      send_frame(fb, sfc_pkg::SRC_RIGHT, 1'b0);
      build_frame(fb, sfc_pkg::MAX_PAYLOAD, sfc_pkg::SRC_LEFT, 16'hFFFF, 16'hFFFF, 8'h00);
      send_frame(fb, sfc_pkg::SRC_LEFT, 1'b0);
      build_frame(fb, 0, sfc_pkg::SRC_PROBE, 16'h0000, 16'h0000, {5'd0, probe_id_cfg[3]});
      send_frame(fb, sfc_pkg::SRC_PROBE, 1'b1);
      build_frame(fb, sfc_pkg::MAX_PAYLOAD, SRC_NONE, 16'h1234, 16'h0000, 8'h00);
      send_frame(fb, SRC_NONE, 1'b0);
      wait_drain();
   endtask

   task automatic test_reset_config_traffic();
      run_random_traffic(450);
   endtask

   task automatic test_config_extremes();
      apply_config(3'd6, 3'd1, 3'd1, 3'd2, 3'd6, 3'd5);
      run_random_traffic(350);
   endtask

   task automatic test_back_to_back();
      apply_config(3'd3, 3'd5, 3'd2, 3'd6, 3'd1, 3'd4);
      no_gaps = 1'b1;
      run_random_traffic(250);
      no_gaps = 1'b0;
   endtask

   // long response stall while one-byte frames keep coming: the pipe fills and req stalls
   task automatic test_response_backpressure();
      logic [7:0] fb[$];
      no_gaps = 1'b1;
      hold_request = 1'b1;
      repeat (60) begin
         fb = {8'($urandom)};
         send_frame(fb, 2'($urandom_range(0, 3)), 1'b0);
      end
      no_gaps = 1'b0;
      wait_drain();
   endtask

   task automatic test_slot_out_of_range();
      apply_config(3'd0, 3'd7, 3'd0, 3'd7, 3'd2, 3'd2);
      run_random_traffic(200);
   endtask

   // response side: random ready, one long hold on request, check every transaction
   initial begin
      int         stretch_left;
      int         hold_left;
      logic       ready_now;
      logic       bad;
      report_type got;
      report_type want;
      stretch_left = 0;
      hold_left = 0;
      ready_now = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.slot = rsp_bus.slot;
            got.object_temp = rsp_bus.object_temp;
            got.ambient_temp = rsp_bus.ambient_temp;
            got.body_temp = rsp_bus.body_temp;
            if (expected_reports.size() == 0) begin
               errors++;
               if (shown < MAX_SHOWN) begin
                  $display("unexpected report: status %0d slot %0d", got.status, got.slot);
                  shown++;
               end
            end
            else begin
               want = expected_reports.pop_front();
               reports_checked++;
               if (want.status == sfc_pkg::ST_STORED) stored_seen++;
               bad = (got.status !== want.status) || (got.slot !== want.slot) ||
                     (got.object_temp !== want.object_temp) ||
                     (got.ambient_temp !== want.ambient_temp) ||
                     (got.body_temp !== want.body_temp);
               if (bad) begin
                  errors++;
                  if (shown < MAX_SHOWN) begin
                     $display("report mismatch (exp/got): status %0d/%0d slot %0d/%0d",
                              want.status, got.status, want.slot, got.slot);
                     $display("   object %0d/%0d ambient %0d/%0d body %0d/%0d",
                              want.object_temp, got.object_temp, want.ambient_temp,
                              got.ambient_temp, want.body_temp, got.body_temp);
                     shown++;
                  end
               end
            end
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_now = 1'b0;
         end
         else if (no_gaps) ready_now = 1'b1;
         else if (stretch_left > 0) stretch_left--;
         else if (ready_now && $urandom_range(0, 99) < 35) begin
            ready_now = 1'b0;
            stretch_left = gap_length();
         end
         else begin
            ready_now = 1'b1;
            stretch_left = $urandom_range(0, 12);
         end
         rsp_bus.ready <= ready_now;
      end
   end

   initial begin
      left_slot_cfg = 3'd1;
      right_slot_cfg = 3'd2;
      for (int k = 0; k < sfc_pkg::NUM_PROBES; k++) probe_id_cfg[k] = 3'(k + 3);
      byte_pos = 0;
      sum_acc = '0;
      frame_len = '0;
      check_byte = '0;
      id_byte = '0;
      object_word = '0;
      ambient_word = '0;
      for (int k = 1; k <= SLOT_COUNT; k++) begin
         slot_object_tbl[k] = '0;
         slot_ambient_tbl[k] = '0;
      end
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = sfc_pkg::CSR_LEFT_SLOT;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.frame_byte = '0;
      req_bus.src_port = sfc_pkg::SRC_LEFT;
      req_bus.last_byte = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_reset_config_traffic();
      test_config_extremes();
      test_back_to_back();
      test_response_backpressure();
      test_slot_out_of_range();

      $display("covered %0d bytes in %0d frames over four slot/ID settings and a long stall",
               bytes_sent, frames_sent);
      $display("checked %0d reports, %0d stored, %0d rejected, %0d errors",
               reports_checked, stored_seen, reports_checked - stored_seen, errors);
      if (errors == 0) begin
         $display("TB_OK");
      end
      else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
